// ===== design/midpoint_line_rasterizer_macros.svh =====
// Assertion macros shared by the line rasterizer RTL.
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MLR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("line rasterizer check failed");

// Next-cycle implication, checked outside reset.
`define MLR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("line rasterizer check failed");

`endif

// ===== design/mlr_pkg.sv =====
// Types and constants of the midpoint line rasterizer.
`default_nettype none

package mlr_pkg;

   localparam int COORD_BITS = 10;
   localparam int WH_BITS    = 11;
   localparam int PY_BITS    = COORD_BITS + 2;
   localparam int FOLD_BITS  = COORD_BITS + 2;
   localparam int DEC_BITS   = COORD_BITS + 4;
   localparam int Q_DEPTH    = 2;

   localparam logic [WH_BITS-1:0] WH_RESET = 11'd512;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   typedef enum logic [1:0] {
      OCT_SHALLOW     = 2'd0,
      OCT_STEEP       = 2'd1,
      OCT_SHALLOW_NEG = 2'd2,
      OCT_STEEP_NEG   = 2'd3
   } octant_type;

   typedef struct packed {
      logic                  kind;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]     pixel_x;
      logic signed [PY_BITS-1:0] pixel_y;
      logic                      last;
   } rsp_type;

   // Endpoints ordered left to right with their extents.
   typedef struct packed {
      logic                         is_load;
      logic [COORD_BITS-1:0]        ax;
      logic [COORD_BITS-1:0]        ay;
      logic [COORD_BITS-1:0]        bx;
      logic [COORD_BITS-1:0]        by;
      logic signed [COORD_BITS:0]   rise;
      logic [COORD_BITS-1:0]        run;
   } order_type;

   // Command passed from front to back.
   typedef struct packed {
      logic                        is_load;
      octant_type                  octant;
      logic signed [FOLD_BITS-1:0] cur_major;
      logic signed [FOLD_BITS-1:0] cur_minor;
      logic signed [FOLD_BITS-1:0] stop_major;
      logic signed [DEC_BITS-1:0]  step_e;
      logic signed [DEC_BITS-1:0]  step_ne;
      logic signed [DEC_BITS-1:0]  decision;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== design/mlr_front.sv =====
// Front end: accepts transactions, orders endpoints and folds lines into the first octant.
`default_nettype none

module mlr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  mlr_pkg::req_type      req,
   output logic                  push,
   output mlr_pkg::cmd_type      cmd,
   input  wire logic             q_full
);
   import mlr_pkg::*;

   logic      s1_valid_ff, s1_valid_in;
   order_type s1_ff, s1_in;
   logic      advance;
   logic      swap;

   logic signed [COORD_BITS:0]   run_s;
   logic signed [COORD_BITS:0]   neg_rise;
   logic signed [FOLD_BITS-1:0]  ax_f, ay_f, bx_f, by_f;
   logic [COORD_BITS-1:0]        span;
   logic [COORD_BITS-1:0]        drop;
   logic [DEC_BITS-1:0]          dec_span, dec_drop, dec_drop2;

   assign push      = s1_valid_ff && !q_full;
   assign advance   = !s1_valid_ff || push;
   assign req_ready = advance;

   // Stage one: order endpoints left to right, first endpoint wins a tie.
   always_comb begin
      swap           = req.start_x > req.end_x;
      s1_in.is_load  = (req.kind == KIND_START);
      s1_in.ax       = swap ? req.end_x   : req.start_x;
      s1_in.ay       = swap ? req.end_y   : req.start_y;
      s1_in.bx       = swap ? req.start_x : req.end_x;
      s1_in.by       = swap ? req.start_y : req.end_y;
      s1_in.rise     = $signed({1'b0, s1_in.by}) - $signed({1'b0, s1_in.ay});
      s1_in.run      = s1_in.bx - s1_in.ax;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
      end
   end

   // Stage two: pick the octant and build the decision terms.
   always_comb begin
      run_s    = $signed({1'b0, s1_ff.run});
      neg_rise = -s1_ff.rise;
      ax_f     = $signed(FOLD_BITS'(s1_ff.ax));
      ay_f     = $signed(FOLD_BITS'(s1_ff.ay));
      bx_f     = $signed(FOLD_BITS'(s1_ff.bx));
      by_f     = $signed(FOLD_BITS'(s1_ff.by));

      cmd.is_load = s1_ff.is_load;
      if (s1_ff.rise > 0 && s1_ff.rise > run_s) begin
         cmd.octant     = OCT_STEEP;
         cmd.cur_major  = ay_f;
         cmd.cur_minor  = ax_f;
         cmd.stop_major = by_f;
         span           = s1_ff.rise[COORD_BITS-1:0];
         drop           = s1_ff.run;
      end else if (s1_ff.rise >= 0) begin
         cmd.octant     = OCT_SHALLOW;
         cmd.cur_major  = ax_f;
         cmd.cur_minor  = ay_f;
         cmd.stop_major = bx_f;
         span           = s1_ff.run;
         drop           = s1_ff.rise[COORD_BITS-1:0];
      end else if (neg_rise <= run_s) begin
         cmd.octant     = OCT_SHALLOW_NEG;
         cmd.cur_major  = ax_f;
         cmd.cur_minor  = -ay_f;
         cmd.stop_major = bx_f;
         span           = s1_ff.run;
         drop           = neg_rise[COORD_BITS-1:0];
      end else begin
         cmd.octant     = OCT_STEEP_NEG;
         cmd.cur_major  = -ay_f;
         cmd.cur_minor  = ax_f;
         cmd.stop_major = -by_f;
         span           = neg_rise[COORD_BITS-1:0];
         drop           = s1_ff.run;
      end

      dec_span     = DEC_BITS'(span);
      dec_drop     = DEC_BITS'(drop);
      dec_drop2    = dec_drop << 1;
      cmd.decision = $signed(dec_span - dec_drop2);
      cmd.step_e   = $signed(dec_drop2);
      cmd.step_ne  = $signed((dec_span - dec_drop) << 1);
   end

endmodule

`default_nettype wire

// ===== design/mlr_queue.sv =====
// Short command queue between the front end and the pixel stepper.
`default_nettype none

module mlr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  mlr_pkg::cmd_type       push_data,
   input  wire logic              pop,
   output logic                   head_valid,
   output mlr_pkg::cmd_type       head,
   output mlr_pkg::q_status_type  status
);
   import mlr_pkg::*;

   localparam int PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(Q_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(Q_DEPTH - 1);

   cmd_type               entry_ff [Q_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_BITS'(Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_valid   = !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/mlr_back.sv =====
// Back end: holds the line state, steps the decision value and registers each pixel.
`default_nettype none

module mlr_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        head_valid,
   input  mlr_pkg::cmd_type                 head,
   output logic                             pop,
   input  wire logic [mlr_pkg::WH_BITS-1:0] window_height,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output mlr_pkg::rsp_type                 rsp
);
   import mlr_pkg::*;

   logic                        active_ff, active_in;
   octant_type                  octant_ff, octant_in;
   logic signed [FOLD_BITS-1:0] cur_major_ff, cur_major_in;
   logic signed [FOLD_BITS-1:0] cur_minor_ff, cur_minor_in;
   logic signed [FOLD_BITS-1:0] stop_major_ff, stop_major_in;
   logic signed [DEC_BITS-1:0]  step_e_ff, step_e_in;
   logic signed [DEC_BITS-1:0]  step_ne_ff, step_ne_in;
   logic signed [DEC_BITS-1:0]  decision_ff, decision_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic                        out_free;
   logic                        emit;
   logic                        is_last;
   logic signed [FOLD_BITS-1:0] neg_major, neg_minor;
   logic [COORD_BITS-1:0]       px, sy;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // Loads never wait on the output; steps wait for a free output slot.
   assign pop       = head_valid && (head.is_load || out_free);
   assign emit      = pop && !head.is_load && active_ff;
   assign is_last   = cur_major_ff >= stop_major_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Map the folded position back to screen space.
   always_comb begin
      neg_major = -cur_major_ff;
      neg_minor = -cur_minor_ff;
      case (octant_ff)
         OCT_SHALLOW: begin
            px = cur_major_ff[COORD_BITS-1:0];
            sy = cur_minor_ff[COORD_BITS-1:0];
         end
         OCT_STEEP: begin
            px = cur_minor_ff[COORD_BITS-1:0];
            sy = cur_major_ff[COORD_BITS-1:0];
         end
         OCT_SHALLOW_NEG: begin
            px = cur_major_ff[COORD_BITS-1:0];
            sy = neg_minor[COORD_BITS-1:0];
         end
         default: begin
            px = cur_minor_ff[COORD_BITS-1:0];
            sy = neg_major[COORD_BITS-1:0];
         end
      endcase
      rsp_in.pixel_x = px;
      rsp_in.pixel_y = $signed(PY_BITS'(window_height) - PY_BITS'(sy));
      rsp_in.last    = is_last;
   end

   always_comb begin
      active_in     = active_ff;
      octant_in     = octant_ff;
      cur_major_in  = cur_major_ff;
      cur_minor_in  = cur_minor_ff;
      stop_major_in = stop_major_ff;
      step_e_in     = step_e_ff;
      step_ne_in    = step_ne_ff;
      decision_in   = decision_ff;
      if (pop && head.is_load) begin
         active_in     = 1'b1;
         octant_in     = head.octant;
         cur_major_in  = head.cur_major;
         cur_minor_in  = head.cur_minor;
         stop_major_in = head.stop_major;
         step_e_in     = head.step_e;
         step_ne_in    = head.step_ne;
         decision_in   = head.decision;
      end else if (emit) begin
         // Positive decision moves east, otherwise north-east.
         if (decision_ff > 0) begin
            decision_in = decision_ff - step_e_ff;
         end else begin
            decision_in  = decision_ff + step_ne_ff;
            cur_minor_in = cur_minor_ff + 1'b1;
         end
         cur_major_in = cur_major_ff + 1'b1;
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      octant_ff     <= octant_in;
      cur_major_ff  <= cur_major_in;
      cur_minor_ff  <= cur_minor_in;
      stop_major_ff <= stop_major_in;
      step_e_ff     <= step_e_in;
      step_ne_ff    <= step_ne_in;
      decision_ff   <= decision_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/midpoint_line_rasterizer.sv =====
// A step transaction passes the stage-one register, a queue entry and the rsp register.
// Throughput: one transaction per cycle, start or step, while rsp is not stalled, limited
// by the single stepper in the back end that updates the decision value once per cycle.
// A two-entry command queue lets the front end keep accepting while the output is stalled.
// Reset (synchronous): no line in progress, queue and output empty, window_height = 512.
`default_nettype none

`include "midpoint_line_rasterizer_macros.svh"

module midpoint_line_rasterizer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  mlr_pkg::req_type                 req,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output mlr_pkg::rsp_type                 rsp,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [mlr_pkg::WH_BITS-1:0] csr_wdata
);
   import mlr_pkg::*;

   logic [WH_BITS-1:0] window_height_ff, window_height_in;
   logic               q_push;
   logic               q_pop;
   logic               head_valid;
   cmd_type            push_cmd;
   cmd_type            head_cmd;
   q_status_type       q_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      window_height_in = window_height_ff;
      if (csr_valid && csr_ready) begin
         window_height_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_height_ff <= WH_RESET;
      end else begin
         window_height_ff <= window_height_in;
      end
   end

   mlr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .push      (q_push),
      .cmd       (push_cmd),
      .q_full    (q_stat.full)
   );

   mlr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (push_cmd),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head       (head_cmd),
      .status     (q_stat)
   );

   mlr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head_cmd),
      .pop           (q_pop),
      .window_height (window_height_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp           (rsp)
   );

   `MLR_ASSERT_SAME(a_push_has_room, q_push, !q_stat.full)
   `MLR_ASSERT_SAME(a_pop_has_data, q_pop, !q_stat.empty)
   `MLR_ASSERT_NEXT(a_queue_fills, q_push && !q_pop && !q_stat.empty, q_stat.full)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the midpoint line rasterizer with randomized handshake pressure.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mlr_pkg::*;

   localparam int PHASE_ITEMS  = 30;
   localparam int DRAIN_CYCLES = 8;
   localparam int TIMEOUT_NS   = 3_000_000;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req       = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [WH_BITS-1:0]  csr_wdata = '0;

   int send_idle_pct = 7;
   int recv_idle_pct = 64;
   int items_pushed   = 0;
   int items_accepted = 0;
   int fail_count     = 0;

   req_type req_pending[$];
   rsp_type pixel_expected[$];

   // Predictor state, folded into the first octant as the block keeps it.
   logic [WH_BITS-1:0]           height_copy   = WH_RESET;
   logic                         line_active   = 1'b0;
   octant_type                   line_octant   = OCT_SHALLOW;
   logic signed [FOLD_BITS-1:0]  major_pos     = '0;
   logic signed [FOLD_BITS-1:0]  minor_pos     = '0;
   logic signed [FOLD_BITS-1:0]  major_stop    = '0;
   logic signed [FOLD_BITS-1:0]  line_span     = '0;
   logic signed [FOLD_BITS-1:0]  line_drop     = '0;
   logic signed [DEC_BITS-1:0]   line_decision = '0;

   midpoint_line_rasterizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic void rasterize(input req_type item);
      logic signed [FOLD_BITS-1:0] ax, ay, bx, by, rise, run, px, sy;
      rsp_type                     pixel;
      logic                        at_end;
      if (item.kind == KIND_START) begin
         // the first endpoint wins a tie on x
         if (item.start_x <= item.end_x) begin
            ax = {2'b00, item.start_x};
            ay = {2'b00, item.start_y};
            bx = {2'b00, item.end_x};
            by = {2'b00, item.end_y};
         end else begin
            ax = {2'b00, item.end_x};
            ay = {2'b00, item.end_y};
            bx = {2'b00, item.start_x};
            by = {2'b00, item.start_y};
         end
         rise = by - ay;
         run  = bx - ax;
         if (rise > 0 && rise > run) begin
            line_octant = OCT_STEEP;
            major_pos   = ay;
            minor_pos   = ax;
            major_stop  = by;
            line_drop   = bx - ax;
         end else if (rise >= 0) begin
            line_octant = OCT_SHALLOW;
            major_pos   = ax;
            minor_pos   = ay;
            major_stop  = bx;
            line_drop   = by - ay;
         end else if (-rise <= run) begin
            line_octant = OCT_SHALLOW_NEG;
            major_pos   = ax;
            minor_pos   = -ay;
            major_stop  = bx;
            line_drop   = ay - by;
         end else begin
            line_octant = OCT_STEEP_NEG;
            major_pos   = -ay;
            minor_pos   = ax;
            major_stop  = -by;
            line_drop   = bx - ax;
         end
         line_span     = major_stop - major_pos;
         line_decision = DEC_BITS'(line_span - 2 * line_drop);
         line_active   = 1'b1;
      end else if (line_active) begin
         case (line_octant)
            OCT_SHALLOW: begin
               px = major_pos;
               sy = minor_pos;
            end
            OCT_STEEP: begin
               px = minor_pos;
               sy = major_pos;
            end
            OCT_SHALLOW_NEG: begin
               px = major_pos;
               sy = -minor_pos;
            end
            default: begin
               px = minor_pos;
               sy = -major_pos;
            end
         endcase
         at_end        = (major_pos >= major_stop);
         pixel.pixel_x = px[COORD_BITS-1:0];
         pixel.pixel_y = {1'b0, height_copy} - sy;
         pixel.last    = at_end;
         pixel_expected.push_back(pixel);
         // zero decision goes north-east
         if (line_decision > 0) begin
            line_decision = DEC_BITS'(line_decision - 2 * line_drop);
         end else begin
            minor_pos     = FOLD_BITS'(minor_pos + 1);
            line_decision = DEC_BITS'(line_decision + 2 * (line_span - line_drop));
         end
         major_pos = FOLD_BITS'(major_pos + 1);
         if (at_end) line_active = 1'b0;
      end
   endfunction

   // Driver: present queued transactions, hold each until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rasterize(req);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req       <= req_pending.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each pixel with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_expected.size() == 0) begin
               $error("unexpected pixel: pixel_x %0d pixel_y %0d last %0d",
                      rsp.pixel_x, rsp.pixel_y, rsp.last);
               fail_count++;
            end else begin
               want = pixel_expected.pop_front();
               if (rsp.pixel_x !== want.pixel_x) begin
                  $error("pixel_x: expected %0d, actual %0d", want.pixel_x, rsp.pixel_x);
                  fail_count++;
               end
               if (rsp.pixel_y !== want.pixel_y) begin
                  $error("pixel_y: expected %0d, actual %0d", want.pixel_y, rsp.pixel_y);
                  fail_count++;
               end
               if (rsp.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp.last);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void push_start(input int sx, input int sy, input int ex, input int ey);
      req_type item;
      item.kind    = KIND_START;
      item.start_x = COORD_BITS'(sx);
      item.start_y = COORD_BITS'(sy);
      item.end_x   = COORD_BITS'(ex);
      item.end_y   = COORD_BITS'(ey);
      req_pending.push_back(item);
      items_pushed++;
   endfunction

   // Step transactions carry random coordinates that the block must ignore.
   function automatic void push_step();
      logic [63:0] noise;
      req_type     item;
      noise     = {$urandom, $urandom};
      item      = noise[$bits(req_type)-1:0];
      item.kind = KIND_STEP;
      req_pending.push_back(item);
      items_pushed++;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > 1023) return 1023;
      return v;
   endfunction

   // Queue one line and its steps; return the number of transactions that do work.
   function automatic int push_random_line();
      int   sx, sy, ex, ey, reach, dx, dy, span, steps, pick;
      logic wide;
      wide = ($urandom_range(99) < 5);
      if ($urandom_range(99) < 3) push_step();
      sx = $urandom_range(1023);
      sy = $urandom_range(1023);
      if (wide) begin
         ex = $urandom_range(1023);
         ey = $urandom_range(1023);
      end else begin
         reach = ($urandom_range(3) == 0) ? 40 : 10;
         if ($urandom_range(9) == 0) sx = $urandom_range(1) ? 1023 : 0;
         if ($urandom_range(9) == 0) sy = $urandom_range(1) ? 1023 : 0;
         ex = clamp_coord(sx + int'($urandom_range(2 * reach)) - reach);
         ey = clamp_coord(sy + int'($urandom_range(2 * reach)) - reach);
      end
      dx   = (ex > sx) ? ex - sx : sx - ex;
      dy   = (ey > sy) ? ey - sy : sy - ey;
      span = ((dx > dy) ? dx : dy) + 1;
      push_start(sx, sy, ex, ey);
      if (wide) begin
         steps = $urandom_range(24, 1);
      end else begin
         pick = $urandom_range(99);
         if (pick < 80) steps = span + (($urandom_range(9) == 0) ? 1 : 0);
         else if (pick < 92) steps = $urandom_range(span - 1);
         else steps = span + $urandom_range(2, 1);
      end
      repeat (steps) push_step();
      return 1 + ((steps < span) ? steps : span);
   endfunction

   task automatic wait_drained();
      while (items_accepted != items_pushed || pixel_expected.size() != 0)
         @(posedge clock);
      // let trailing start or idle-step transactions settle
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_height(input logic [WH_BITS-1:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      height_copy = value;
   endtask

   initial begin
      logic [WH_BITS-1:0] height;
      int                 made;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines at the reset height
      push_step();
      push_start(1023, 1023, 0, 0);
      repeat (2) push_step();
      push_start(1023, 0, 1023, 0);
      push_step();
      push_start(20, 20, 21, 23);
      repeat (4) push_step();
      push_start(33, 28, 30, 30);
      repeat (4) push_step();
      push_start(40, 40, 41, 37);
      repeat (4) push_step();
      push_start(50, 52, 50, 50);
      repeat (3) push_step();
      push_step();
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase < 2) begin
            send_idle_pct <= 7;
            recv_idle_pct <= 64;
         end else if (phase < 4) begin
            send_idle_pct <= 64;
            recv_idle_pct <= 7;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         case (phase)
            0:       height = 11'd1024;
            1:       height = 11'd1;
            2:       height = 11'd0;
            3:       height = 11'd2047;
            4:       height = WH_BITS'($urandom_range(1024, 1));
            default: height = WH_BITS'($urandom_range(2047));
         endcase
         write_height(height);
         made = 0;
         while (made < PHASE_ITEMS) made += push_random_line();
         if (phase == 5) begin
            // one full-length diagonal across the whole coordinate range
            push_start(1023, 0, 0, 1023);
            repeat (1024) push_step();
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
